/* hw/rtl/dwc_pkg.sv */
`default_nettype none

package dwc_pkg;

    localparam int TABLE_DEPTH  = 32;
    localparam int MAX_CHARS    = 8;
    localparam int RESULT_LIMIT = 32;

    localparam int CHAR_W = 8;
    localparam int KEY_W  = 64;
    localparam int CNT_W  = 16;
    localparam int USED_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W  = $clog2(MAX_CHARS + 1);
    localparam int LIM_W  = $clog2(RESULT_LIMIT + 1);

    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

    typedef enum logic [1:0] {
        KIND_DUP   = 2'd0,
        KIND_NONE  = 2'd1,
        KIND_SPACE = 2'd2,
        KIND_LONG  = 2'd3
    } kind_t;

    // broadcast controls for the row of table cells
    typedef struct packed {
        logic shift;   // every cell takes its upper neighbor
        logic update;  // matching cell bumps its count
        logic append;  // selected cell loads the key with count 1
    } cell_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/dwc_cell.sv */
`default_nettype none

module dwc_cell (
    input  logic                       clk,
    input  dwc_pkg::cell_ctl_t         ctl,
    input  logic                       sel,
    input  logic                       in_use,
    input  logic [dwc_pkg::KEY_W-1:0]  key,
    input  logic [dwc_pkg::KEY_W-1:0]  nb_word,
    input  logic [dwc_pkg::CNT_W-1:0]  nb_cnt,
    output logic [dwc_pkg::KEY_W-1:0]  word,
    output logic [dwc_pkg::CNT_W-1:0]  cnt,
    output logic                       match
);
    import dwc_pkg::*;

    logic [KEY_W-1:0] word_reg;
    logic [KEY_W-1:0] word_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign match = in_use && (word_reg == key);
    assign word  = word_reg;
    assign cnt   = cnt_reg;

    always_comb
    begin
        word_next = word_reg;
        cnt_next  = cnt_reg;
        if (ctl.shift)
        begin
            word_next = nb_word;
            cnt_next  = nb_cnt;
        end
        else if (ctl.append && sel)
        begin
            word_next = key;
            cnt_next  = CNT_W'(1);
        end
        else if (ctl.update && match && (cnt_reg != {CNT_W{1'b1}}))
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        cnt_reg  <= cnt_next;
    end

endmodule

`default_nettype wire

/* hw/rtl/duplicate_word_counter_core.sv */
// Duplicate word counter.
// Input stream: one character per item. s_axis_tdata = ch, s_axis_tuser = word_end,
// s_axis_tlast = set_end (also ends the word). Output stream: one result per item,
// m_axis_tdata = {occurrences, word_key}, m_axis_tuser = kind, m_axis_tlast = last.
// The last character of a word is first packed into the key, then the key is
// compared against all table cells at once to bump or append. At set end the
// table row shifts toward cell 0 one entry per cycle while the output register is
// free, and the next character is taken only after that walk ends. Space and
// too-long errors load their one result at the accept edge, table full at the
// compare edge. Results leave through a one-deep output register; while it is
// full and the receiver holds tready low, the walk and the input both wait.
// Reset empties the table at once (the used count goes to zero), no clearing pass.
// Until set end a result item is held back one step so that tlast lands on the
// last duplicate entry.

`default_nettype none

module duplicate_word_counter_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] ch
    input  logic         s_axis_tuser,   // [0] word_end
    input  logic         s_axis_tlast,   // set_end
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [79:0]  m_axis_tdata,   // [63:0] word_key, [79:64] occurrences
    output logic [1:0]   m_axis_tuser,   // [1:0] kind
    output logic         m_axis_tlast    // last
);
    import dwc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_DUMP = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [USED_W-1:0] used_reg, used_next;
    logic [KEY_W-1:0]  buf_reg, buf_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              discard_reg, discard_next;
    logic              send_reg, send_next;
    logic [USED_W-1:0] rem_reg, rem_next;
    logic [LIM_W-1:0]  taken_reg, taken_next;
    logic              held_valid_reg, held_valid_next;
    logic [KEY_W-1:0]  held_key_reg, held_key_next;
    logic [CNT_W-1:0]  held_cnt_reg, held_cnt_next;
    logic              out_valid_reg, out_valid_next;
    kind_t             out_kind_reg, out_kind_next;
    logic [KEY_W-1:0]  out_key_reg, out_key_next;
    logic [CNT_W-1:0]  out_cnt_reg, out_cnt_next;
    logic              out_last_reg, out_last_next;

    cell_ctl_t              ctl;
    logic [KEY_W-1:0]       cell_word [TABLE_DEPTH];
    logic [CNT_W-1:0]       cell_cnt  [TABLE_DEPTH];
    logic [KEY_W-1:0]       nb_word   [TABLE_DEPTH];
    logic [CNT_W-1:0]       nb_cnt    [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] cell_match;
    logic [TABLE_DEPTH-1:0] cell_sel;
    logic [TABLE_DEPTH-1:0] cell_in_use;
    logic                   hit;
    logic                   out_free;
    logic                   in_acc;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            if (gi == TABLE_DEPTH - 1)
            begin : g_end
                assign nb_word[gi] = cell_word[gi];
                assign nb_cnt[gi]  = cell_cnt[gi];
            end
            else
            begin : g_mid
                assign nb_word[gi] = cell_word[gi+1];
                assign nb_cnt[gi]  = cell_cnt[gi+1];
            end
            assign cell_sel[gi]    = (used_reg == USED_W'(gi));
            assign cell_in_use[gi] = (USED_W'(gi) < used_reg);

            dwc_cell u_cell (
                .clk     (clk),
                .ctl     (ctl),
                .sel     (cell_sel[gi]),
                .in_use  (cell_in_use[gi]),
                .key     (buf_reg),
                .nb_word (nb_word[gi]),
                .nb_cnt  (nb_cnt[gi]),
                .word    (cell_word[gi]),
                .cnt     (cell_cnt[gi]),
                .match   (cell_match[gi])
            );
        end
    endgenerate

    assign hit           = |cell_match;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_cnt_reg, out_key_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        buf_next        = buf_reg;
        idx_next        = idx_reg;
        discard_next    = discard_reg;
        send_next       = send_reg;
        rem_next        = rem_reg;
        taken_next      = taken_reg;
        held_valid_next = held_valid_reg;
        held_key_next   = held_key_reg;
        held_cnt_next   = held_cnt_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_kind_next   = out_kind_reg;
        out_key_next    = out_key_reg;
        out_cnt_next    = out_cnt_reg;
        out_last_next   = out_last_reg;
        ctl             = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (discard_reg)
                    begin
                        if (s_axis_tlast)
                        begin
                            used_next    = '0;
                            discard_next = 1'b0;
                        end
                    end
                    else if ((s_axis_tdata == SPACE_CHAR) || (idx_reg >= IDX_W'(MAX_CHARS)))
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = (s_axis_tdata == SPACE_CHAR) ? KIND_SPACE : KIND_LONG;
                        out_key_next   = '0;
                        out_cnt_next   = '0;
                        out_last_next  = 1'b1;
                        buf_next       = '0;
                        idx_next       = '0;
                        if (s_axis_tlast)
                            used_next = '0;
                        else
                            discard_next = 1'b1;
                    end
                    else
                    begin
                        for (int b = 0; b < MAX_CHARS; b++)
                        begin
                            if (idx_reg == IDX_W'(b))
                                buf_next[b*CHAR_W +: CHAR_W] = s_axis_tdata;
                        end
                        idx_next = idx_reg + IDX_W'(1);
                        if (s_axis_tuser || s_axis_tlast)
                        begin
                            send_next  = s_axis_tlast;
                            state_next = S_CMP;
                        end
                    end
                end
            end

            S_CMP:
            begin
                if (out_free)
                begin
                    ctl.update = 1'b1;
                    buf_next   = '0;
                    idx_next   = '0;
                    if (!hit && (used_reg >= USED_W'(TABLE_DEPTH)))
                    begin
                        // table full
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_LONG;
                        out_key_next   = '0;
                        out_cnt_next   = '0;
                        out_last_next  = 1'b1;
                        if (send_reg)
                            used_next = '0;
                        else
                            discard_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        if (!hit)
                        begin
                            ctl.append = 1'b1;
                            used_next  = used_reg + USED_W'(1);
                        end
                        if (send_reg)
                        begin
                            rem_next        = used_next;
                            taken_next      = '0;
                            held_valid_next = 1'b0;
                            state_next      = S_DUMP;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end

            S_DUMP:
            begin
                if (out_free)
                begin
                    if (rem_reg != '0)
                    begin
                        ctl.shift = 1'b1;
                        rem_next  = rem_reg - USED_W'(1);
                        if ((cell_cnt[0] > CNT_W'(1)) && (taken_reg < LIM_W'(RESULT_LIMIT)))
                        begin
                            taken_next = taken_reg + LIM_W'(1);
                            if (held_valid_reg)
                            begin
                                out_valid_next = 1'b1;
                                out_kind_next  = KIND_DUP;
                                out_key_next   = held_key_reg;
                                out_cnt_next   = held_cnt_reg;
                                out_last_next  = 1'b0;
                            end
                            held_valid_next = 1'b1;
                            held_key_next   = cell_word[0];
                            held_cnt_next   = cell_cnt[0];
                        end
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_last_next  = 1'b1;
                        if (held_valid_reg)
                        begin
                            out_kind_next = KIND_DUP;
                            out_key_next  = held_key_reg;
                            out_cnt_next  = held_cnt_reg;
                        end
                        else
                        begin
                            out_kind_next = KIND_NONE;
                            out_key_next  = '0;
                            out_cnt_next  = '0;
                        end
                        held_valid_next = 1'b0;
                        used_next       = '0;
                        discard_next    = 1'b0;
                        state_next      = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            buf_reg        <= '0;
            idx_reg        <= '0;
            discard_reg    <= 1'b0;
            send_reg       <= 1'b0;
            rem_reg        <= '0;
            taken_reg      <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            buf_reg        <= buf_next;
            idx_reg        <= idx_next;
            discard_reg    <= discard_next;
            send_reg       <= send_next;
            rem_reg        <= rem_next;
            taken_reg      <= taken_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_key_reg <= held_key_next;
        held_cnt_reg <= held_cnt_next;
        out_kind_reg <= out_kind_next;
        out_key_reg  <= out_key_next;
        out_cnt_reg  <= out_cnt_next;
        out_last_reg <= out_last_next;
    end

    // table entries are distinct, so a key hits at most one cell; the walk
    // duplicates the top cell, so only the compare cycle is checked
    a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> $onehot0(cell_match))
        else $error("more than one table cell matched");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_W'(TABLE_DEPTH))
        else $error("entry count past table depth");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_W'(MAX_CHARS))
        else $error("character index past word limit");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != KIND_DUP)) |-> m_axis_tlast)
        else $error("non-entry result without last");

    a_walk_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP) |-> (!discard_reg && (buf_reg == '0)))
        else $error("table walk with discard set or word pending");

    // errors in the middle of a set keep the table, so only set end results count
    a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast
         && ((m_axis_tuser == KIND_DUP) || (m_axis_tuser == KIND_NONE))
         && !$past(m_axis_tvalid && m_axis_tlast))
        |-> (used_reg == '0))
        else $error("final result left entries in the table");

endmodule

`default_nettype wire
